// File: design/msp_frame_receiver_defines.svh
// Assertion macros for the frame receiver checker.
`ifndef MSP_FRAME_RECEIVER_DEFINES_SVH
`define MSP_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MSP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define MSP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

// File: design/msp_pkg.sv
// Shared constants and types for the frame receiver.
`default_nettype none

package msp_pkg;

  localparam int BufferDepth = 64;
  localparam int AddrW       = $clog2(BufferDepth);
  localparam int SizeW       = 7;

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharM      = 8'h4D;
  localparam logic [7:0] CharLt     = 8'h3C;
  localparam logic [7:0] MaxSize    = 8'(BufferDepth);

  // Handed from the parser to the readout on a good checksum.
  typedef struct packed {
    logic             start;
    logic [7:0]       command;
    logic [SizeW-1:0] size;
  } frame_start_t;

endpackage

`default_nettype wire

// File: design/msp_payload_ram.sv
// Payload store: one write port, one registered read port.
`default_nettype none

module msp_payload_ram (
  input  wire logic                      clk_i,
  input  wire logic                      wr_en_i,
  input  wire logic [msp_pkg::AddrW-1:0] wr_addr_i,
  input  wire logic [7:0]                wr_data_i,
  input  wire logic                      rd_en_i,
  input  wire logic [msp_pkg::AddrW-1:0] rd_addr_i,
  output logic      [7:0]                rd_data_o
);

  logic [7:0] mem [msp_pkg::BufferDepth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: design/msp_parser.sv
// Header, size and checksum tracking; writes payload bytes to the store.
`default_nettype none

module msp_parser (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      beat_i,
  input  wire logic [7:0]                rx_byte_i,
  output logic                           wr_en_o,
  output logic      [msp_pkg::AddrW-1:0] wr_addr_o,
  output logic      [7:0]                wr_data_o,
  output msp_pkg::frame_start_t          frame_o
);

  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhDollar = 3'd1;
  localparam logic [2:0] PhM      = 3'd2;
  localparam logic [2:0] PhArrow  = 3'd3;
  localparam logic [2:0] PhSize   = 3'd4;
  localparam logic [2:0] PhBody   = 3'd5;

  logic [2:0]                phase_q, phase_d;
  logic [msp_pkg::SizeW-1:0] size_q, size_d;
  logic [msp_pkg::SizeW-1:0] count_q, count_d;
  logic [7:0]                xor_q, xor_d;
  logic [7:0]                cmd_q, cmd_d;
  logic                      in_body;

  assign in_body = (count_q < size_q);

  always_comb begin
    phase_d         = phase_q;
    size_d          = size_q;
    count_d         = count_q;
    xor_d           = xor_q;
    cmd_d           = cmd_q;
    wr_en_o         = 1'b0;
    frame_o.start   = 1'b0;
    frame_o.command = cmd_q;
    frame_o.size    = size_q;
    if (beat_i) begin
      case (phase_q)
        PhIdle: begin
          if (rx_byte_i == msp_pkg::CharDollar) phase_d = PhDollar;
        end
        PhDollar: phase_d = (rx_byte_i == msp_pkg::CharM) ? PhM : PhIdle;
        PhM:      phase_d = (rx_byte_i == msp_pkg::CharLt) ? PhArrow : PhIdle;
        PhArrow: begin
          if (rx_byte_i > msp_pkg::MaxSize) begin
            phase_d = PhIdle;
          end else begin
            size_d  = rx_byte_i[msp_pkg::SizeW-1:0];
            xor_d   = rx_byte_i;
            count_d = '0;
            phase_d = PhSize;
          end
        end
        PhSize: begin
          xor_d   = xor_q ^ rx_byte_i;
          cmd_d   = rx_byte_i;
          phase_d = PhBody;
        end
        PhBody: begin
          if (in_body) begin
            xor_d   = xor_q ^ rx_byte_i;
            wr_en_o = 1'b1;
            count_d = count_q + 1'b1;
          end else begin
            // checksum byte: hand the frame over on a match, drop it otherwise
            frame_o.start = (xor_q == rx_byte_i);
            phase_d       = PhIdle;
          end
        end
        default: phase_d = PhIdle;
      endcase
    end
  end

  assign wr_addr_o = count_q[msp_pkg::AddrW-1:0];
  assign wr_data_o = rx_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      size_q  <= '0;
      count_q <= '0;
      xor_q   <= '0;
      cmd_q   <= '0;
    end else begin
      phase_q <= phase_d;
      size_q  <= size_d;
      count_q <= count_d;
      xor_q   <= xor_d;
      cmd_q   <= cmd_d;
    end
  end

endmodule

`default_nettype wire

// File: design/msp_readout.sv
// Reads the stored payload back and presents one result per beat.
`default_nettype none

module msp_readout (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire msp_pkg::frame_start_t     frame_i,
  output logic                           busy_o,
  output logic                           rd_en_o,
  output logic      [msp_pkg::AddrW-1:0] rd_addr_o,
  input  wire logic [7:0]                rd_data_i,
  output logic      [7:0]                command_code_o,
  output logic      [msp_pkg::SizeW-1:0] payload_size_o,
  output logic      [msp_pkg::AddrW-1:0] byte_index_o,
  output logic      [7:0]                payload_byte_o,
  output logic                           has_data_o,
  output logic                           last_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StShow = 2'd2;

  logic [1:0]                state_q, state_d;
  logic [msp_pkg::AddrW-1:0] idx_q, idx_d;
  logic [msp_pkg::SizeW-1:0] size_q, size_d;
  logic [7:0]                cmd_q, cmd_d;
  logic [7:0]                data_q, data_d;
  logic                      has_data;
  logic                      is_last;

  assign has_data = (size_q != '0);
  assign is_last  = !has_data ||
                    ({1'b0, idx_q} + msp_pkg::SizeW'(1) == size_q);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    size_d    = size_q;
    cmd_d     = cmd_q;
    data_d    = data_q;
    rd_en_o   = 1'b0;
    rd_addr_o = idx_q;
    case (state_q)
      StIdle: begin
        if (frame_i.start) begin
          size_d    = frame_i.size;
          cmd_d     = frame_i.command;
          idx_d     = '0;
          rd_addr_o = '0;
          rd_en_o   = (frame_i.size != '0);
          // an empty payload has nothing to fetch
          state_d   = (frame_i.size != '0) ? StRead : StShow;
        end
      end
      StRead: begin
        data_d  = rd_data_i;
        state_d = StShow;
      end
      StShow: begin
        if (out_ready_i) begin
          if (is_last) begin
            state_d = StIdle;
          end else begin
            idx_d     = idx_q + 1'b1;
            rd_addr_o = idx_q + 1'b1;
            rd_en_o   = 1'b1;
            state_d   = StRead;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    size_q <= size_d;
    cmd_q  <= cmd_d;
    data_q <= data_d;
  end

  assign busy_o         = (state_q != StIdle);
  assign out_valid_o    = (state_q == StShow);
  assign command_code_o = cmd_q;
  assign payload_size_o = size_q;
  assign byte_index_o   = has_data ? idx_q : '0;
  assign payload_byte_o = has_data ? data_q : 8'h00;
  assign has_data_o     = has_data;
  assign last_o         = is_last;

endmodule

`default_nettype wire

// File: design/msp_frame_receiver.sv
// Top level of the serial request frame receiver.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_ready_o   rx_byte_i
//   out      source     out_valid_o/out_ready_i command_code_o .. last_o
//
// The parser takes header, size, command and payload bytes back to back while in_ready_o is high.
// A matching checksum byte starts a readout of the payload store: each result
// takes a store read and then an output beat, which can stall.
// in_ready_o stays low after the checksum beat until the last result is taken.
// Reset clears the parser and readout control; the store is not cleared.
`default_nettype none

module msp_frame_receiver (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [7:0]                rx_byte_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic      [7:0]                command_code_o,
  output logic      [msp_pkg::SizeW-1:0] payload_size_o,
  output logic      [msp_pkg::AddrW-1:0] byte_index_o,
  output logic      [7:0]                payload_byte_o,
  output logic                           has_data_o,
  output logic                           last_o
);

  logic                      beat;
  logic                      busy;
  logic                      wr_en;
  logic [msp_pkg::AddrW-1:0] wr_addr;
  logic [7:0]                wr_data;
  logic                      rd_en;
  logic [msp_pkg::AddrW-1:0] rd_addr;
  logic [7:0]                rd_data;
  msp_pkg::frame_start_t     frame;

  assign in_ready_o = !busy;
  assign beat       = in_valid_i && in_ready_o;

  msp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat),
    .rx_byte_i (rx_byte_i),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .frame_o   (frame)
  );

  msp_payload_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  msp_readout u_readout (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_i        (frame),
    .busy_o         (busy),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .command_code_o (command_code_o),
    .payload_size_o (payload_size_o),
    .byte_index_o   (byte_index_o),
    .payload_byte_o (payload_byte_o),
    .has_data_o     (has_data_o),
    .last_o         (last_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

endmodule

`default_nettype wire

// File: design/msp_checker.sv
// Port-level checks for the frame receiver, bound to the top level.
`default_nettype none
`include "msp_frame_receiver_defines.svh"

module msp_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_ready_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic [7:0]                command_code_o,
  input wire logic [msp_pkg::SizeW-1:0] payload_size_o,
  input wire logic [msp_pkg::AddrW-1:0] byte_index_o,
  input wire logic [7:0]                payload_byte_o,
  input wire logic                      has_data_o,
  input wire logic                      last_o
);

  // a stalled result holds
  `MSP_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(payload_byte_o) && $stable(byte_index_o) && $stable(last_o))

  // no new byte is taken while results are pending
  `MSP_ASSERT_IMP(a_no_overlap, out_valid_o, !in_ready_o)

  // an empty frame gives exactly one zero result
  `MSP_ASSERT_IMP(a_empty_shape, out_valid_o && !has_data_o,
    last_o && payload_byte_o == 8'h00 && byte_index_o == '0 && payload_size_o == '0)

  // a result with data lies inside its frame and the run continues after a non-last beat
  `MSP_ASSERT_IMP(a_index_range, out_valid_o && has_data_o,
    {1'b0, byte_index_o} < payload_size_o)

  `MSP_ASSERT_NXT(a_run_continues, out_valid_o && out_ready_i && !last_o,
    !in_ready_o && $stable(command_code_o))

endmodule

bind msp_frame_receiver msp_checker u_msp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .command_code_o (command_code_o),
  .payload_size_o (payload_size_o),
  .byte_index_o   (byte_index_o),
  .payload_byte_o (payload_byte_o),
  .has_data_o     (has_data_o),
  .last_o         (last_o)
);

`default_nettype wire

// File: test/msp_frame_receiver_tb.sv
// Self-checking testbench for the serial request frame receiver.
`default_nettype none

module msp_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 20;
  localparam int HoldCycles  = 400;

  typedef enum logic [2:0] {
    PhIdle, PhDollar, PhM, PhArrow, PhSize, PhBody
  } parse_phase_e;

  typedef struct packed {
    logic [7:0]                cmd_code;
    logic [msp_pkg::SizeW-1:0] pay_size;
    logic [msp_pkg::AddrW-1:0] idx;
    logic [7:0]                pay_byte;
    logic                      has_data;
    logic                      last;
  } frame_beat_t;

  typedef struct {
    logic [7:0]  rx;
    bit          typed;
    bit          emits;
    frame_beat_t beat;
  } stim_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [7:0]                rx_byte_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [7:0]                command_code_o;
  logic [msp_pkg::SizeW-1:0] payload_size_o;
  logic [msp_pkg::AddrW-1:0] byte_index_o;
  logic [7:0]                payload_byte_o;
  logic                      has_data_o;
  logic                      last_o;

  // frame parser mirror
  parse_phase_e              rx_phase = PhIdle;
  logic [msp_pkg::SizeW-1:0] frame_len = '0;
  logic [msp_pkg::SizeW-1:0] bytes_seen = '0;
  logic [7:0]                check_xor = '0;
  logic [7:0]                frame_cmd = '0;
  logic [7:0]                payload_mem [msp_pkg::BufferDepth];

  frame_beat_t frame_beats_new [$];
  frame_beat_t beats_due [$];
  frame_beat_t head_beat;
  stim_row_t   directed_rows [$];

  int error_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int cycle_count    = 0;

  always #5 clk_i = ~clk_i;

  msp_frame_receiver u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .command_code_o (command_code_o),
    .payload_size_o (payload_size_o),
    .byte_index_o   (byte_index_o),
    .payload_byte_o (payload_byte_o),
    .has_data_o     (has_data_o),
    .last_o         (last_o)
  );

  // Advance the parser mirror by one accepted byte; stage any beats it emits.
  function automatic void parse_rx_byte(input logic [7:0] b);
    case (rx_phase)
      PhIdle: begin
        if (b == msp_pkg::CharDollar) rx_phase = PhDollar;
      end
      PhDollar: rx_phase = (b == msp_pkg::CharM) ? PhM : PhIdle;
      PhM:      rx_phase = (b == msp_pkg::CharLt) ? PhArrow : PhIdle;
      PhArrow: begin
        if (b > msp_pkg::MaxSize) begin
          rx_phase = PhIdle;
        end else begin
          frame_len  = b[msp_pkg::SizeW-1:0];
          check_xor  = b;
          bytes_seen = '0;
          rx_phase   = PhSize;
        end
      end
      PhSize: begin
        check_xor = check_xor ^ b;
        frame_cmd = b;
        rx_phase  = PhBody;
      end
      PhBody: begin
        if (bytes_seen < frame_len) begin
          check_xor = check_xor ^ b;
          payload_mem[bytes_seen[msp_pkg::AddrW-1:0]] = b;
          bytes_seen = bytes_seen + 1'b1;
        end else begin
          if (check_xor == b) begin
            if (frame_len == 0) begin
              frame_beats_new.push_back('{cmd_code: frame_cmd, pay_size: '0, idx: '0,
                                          pay_byte: 8'h00, has_data: 1'b0,
                                          last: 1'b1});
            end else begin
              for (int i = 0; i < frame_len; i++) begin
                frame_beats_new.push_back('{cmd_code: frame_cmd, pay_size: frame_len,
                                            idx: msp_pkg::AddrW'(i),
                                            pay_byte: payload_mem[i],
                                            has_data: 1'b1,
                                            last: (i + 1 == frame_len)});
              end
            end
          end
          rx_phase = PhIdle;
        end
      end
      default: rx_phase = PhIdle;
    endcase
  endfunction

  function automatic stim_row_t plain_row(input logic [7:0] b);
    plain_row = '{rx: b, typed: 1'b0, emits: 1'b0, beat: '0};
  endfunction

  function automatic stim_row_t typed_row(input logic [7:0] b, input bit emits,
                                         input frame_beat_t beat);
    typed_row = '{rx: b, typed: 1'b1, emits: emits, beat: beat};
  endfunction

  // Offer one byte, hold it until accepted, then update the mirror.
  task automatic offer_byte(input logic [7:0] b, input bit keep);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    parse_rx_byte(b);
    if (keep) begin
      foreach (frame_beats_new[k]) beats_due.push_back(frame_beats_new[k]);
      frame_beats_new.delete();
    end
  endtask

  // Mostly well-formed frames with random content, plus noise and broken frames.
  task automatic run_phase(input int items, input int send_pct, input int stall_pct);
    int         sent;
    int         kind;
    int         len;
    int         pick;
    logic [7:0] cmd_b;
    logic [7:0] chk;
    logic [7:0] b;
    logic [7:0] bytes_q [$];
    sent           = 0;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    while (sent < items) begin
      bytes_q.delete();
      kind = $urandom_range(99);
      if (kind < 8) begin
        // idle noise, mostly ignored by the parser
        repeat ($urandom_range(1, 3)) begin
          b = 8'($urandom_range(255));
          offer_byte(b, 1'b1);
          sent++;
        end
      end else begin
        bytes_q.push_back(msp_pkg::CharDollar);
        if (kind < 14) begin
          b = 8'($urandom_range(255));
          if ($urandom_range(1)) begin
            if (b == msp_pkg::CharM) b = ~b;
            bytes_q.push_back(b);
          end else begin
            if (b == msp_pkg::CharLt) b = ~b;
            bytes_q.push_back(msp_pkg::CharM);
            bytes_q.push_back(b);
          end
        end else begin
          bytes_q.push_back(msp_pkg::CharM);
          bytes_q.push_back(msp_pkg::CharLt);
          if (kind < 22) begin
            bytes_q.push_back(8'($urandom_range(msp_pkg::BufferDepth + 1, 255)));
          end else begin
            pick = $urandom_range(99);
            if (pick < 75)      len = $urandom_range(0, 6);
            else if (pick < 90) len = $urandom_range(7, msp_pkg::BufferDepth - 1);
            else                len = msp_pkg::BufferDepth;
            cmd_b = 8'($urandom_range(255));
            chk   = 8'(len) ^ cmd_b;
            bytes_q.push_back(8'(len));
            bytes_q.push_back(cmd_b);
            repeat (len) begin
              b   = 8'($urandom_range(255));
              chk = chk ^ b;
              bytes_q.push_back(b);
            end
            if (kind < 32) chk = chk ^ 8'($urandom_range(1, 255));
            bytes_q.push_back(chk);
          end
        end
        foreach (bytes_q[k]) offer_byte(bytes_q[k], 1'b1);
        sent += bytes_q.size();
      end
    end
  endtask

  // Receiver side: random stalls, plus a long hold-off when requested.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (beats_due.size() == 0) begin
        $error("unexpected beat: command_code %0h byte_index %0d", command_code_o,
               byte_index_o);
        error_count++;
      end else begin
        head_beat = beats_due.pop_front();
        if (command_code_o !== head_beat.cmd_code) begin
          $error("command_code: expected %0h, got %0h", head_beat.cmd_code, command_code_o);
          error_count++;
        end
        if (payload_size_o !== head_beat.pay_size) begin
          $error("payload_size: expected %0d, got %0d", head_beat.pay_size, payload_size_o);
          error_count++;
        end
        if (byte_index_o !== head_beat.idx) begin
          $error("byte_index: expected %0d, got %0d", head_beat.idx, byte_index_o);
          error_count++;
        end
        if (payload_byte_o !== head_beat.pay_byte) begin
          $error("payload_byte: expected %0h, got %0h", head_beat.pay_byte, payload_byte_o);
          error_count++;
        end
        if (has_data_o !== head_beat.has_data) begin
          $error("has_data: expected %0b, got %0b", head_beat.has_data, has_data_o);
          error_count++;
        end
        if (last_o !== head_beat.last) begin
          $error("last: expected %0b, got %0b", head_beat.last, last_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i  = 8'h00;
    for (int i = 0; i < msp_pkg::BufferDepth; i++) payload_mem[i] = 8'h00;

    // second dollar after a dollar drops back to idle without restarting
    directed_rows.push_back(plain_row(msp_pkg::CharDollar));
    directed_rows.push_back(typed_row(msp_pkg::CharDollar, 1'b0, '0));
    // wrong byte after the M
    directed_rows.push_back(plain_row(msp_pkg::CharDollar));
    directed_rows.push_back(plain_row(msp_pkg::CharM));
    directed_rows.push_back(typed_row(8'h58, 1'b0, '0));
    // empty payload, all-ones command
    directed_rows.push_back(plain_row(msp_pkg::CharDollar));
    directed_rows.push_back(plain_row(msp_pkg::CharM));
    directed_rows.push_back(plain_row(msp_pkg::CharLt));
    directed_rows.push_back(plain_row(8'h00));
    directed_rows.push_back(plain_row(8'hFF));
    directed_rows.push_back(typed_row(8'hFF, 1'b1,
                            '{cmd_code: 8'hFF, pay_size: '0, idx: '0, pay_byte: 8'h00,
                              has_data: 1'b0, last: 1'b1}));
    // size one above the buffer depth
    directed_rows.push_back(plain_row(msp_pkg::CharDollar));
    directed_rows.push_back(plain_row(msp_pkg::CharM));
    directed_rows.push_back(plain_row(msp_pkg::CharLt));
    directed_rows.push_back(typed_row(msp_pkg::MaxSize + 8'd1, 1'b0, '0));
    // one payload byte, zero command
    directed_rows.push_back(plain_row(msp_pkg::CharDollar));
    directed_rows.push_back(plain_row(msp_pkg::CharM));
    directed_rows.push_back(plain_row(msp_pkg::CharLt));
    directed_rows.push_back(plain_row(8'h01));
    directed_rows.push_back(plain_row(8'h00));
    directed_rows.push_back(plain_row(8'hFF));
    directed_rows.push_back(typed_row(8'hFE, 1'b1,
                            '{cmd_code: 8'h00, pay_size: 7'd1, idx: '0, pay_byte: 8'hFF,
                              has_data: 1'b1, last: 1'b1}));
    // bad checksum: drop silently
    directed_rows.push_back(plain_row(msp_pkg::CharDollar));
    directed_rows.push_back(plain_row(msp_pkg::CharM));
    directed_rows.push_back(plain_row(msp_pkg::CharLt));
    directed_rows.push_back(plain_row(8'h00));
    directed_rows.push_back(plain_row(8'h12));
    directed_rows.push_back(typed_row(8'h00, 1'b0, '0));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_byte(directed_rows[i].rx, !directed_rows[i].typed);
      if (directed_rows[i].typed) begin
        frame_beats_new.delete();
        if (directed_rows[i].emits) beats_due.push_back(directed_rows[i].beat);
      end
    end

    // hold the output long enough for the input to back up
    hold_left = HoldCycles;
    run_phase(55, 0, 0);
    run_phase(55, 87, 0);
    run_phase(55, 0, 87);
    run_phase(55, 12, 12);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
